@@ hw/rtl/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// No dependencies; imported by every module of the block.
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int GLYPH_W = 8;

    // One line segment: two endpoints and the glyph to draw with.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [GLYPH_W-1:0] glyph;
    } segment_t;

    // One emitted character cell.
    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [GLYPH_W-1:0] cell_glyph;
        logic               last_cell;
    } cell_t;

    // Commands from the sequencer to the interpolation stepper.
    typedef struct packed {
        logic load;
        logic advance;
    } step_ctl_t;

endpackage

@@ hw/rtl/line_rasterizer.sv @@
// Top level of the line rasterizer: sequencer, serial span unit and stepper.
// Depends on lr_pkg, lr_serial_sub and lr_step.
//
//  channel   direction  handshake              payload
//  segment   in         start / busy           segment_t (endpoints, glyph)
//  cell      out        cell_strobe (1 cycle)  cell_t (x, y, glyph, last_cell)
//
// An item yields n = max(|dx|, |dy|) + 1 cells: the bit-serial subtractors
// form the spans, the endpoints are ordered and the stepper loaded, then
// one cell is shown a cycle.
// busy stays high from acceptance until the last cell is shown.
// Reset clears the sequencer and the strobe; nothing else needs it.
// The receiver takes every cell in the cycle it is shown: there is no stall.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  segment_t segment,
    output logic     cell_strobe,
    output cell_t    cell_data
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = (CB > 1) ? $clog2(CB) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CB-1:0]        x1_reg;
    logic [CB-1:0]        y1_reg;
    logic [CB-1:0]        x2_reg;
    logic [CB-1:0]        y2_reg;
    logic [GLYPH_W-1:0]   glyph_reg;
    logic                 step_x_reg;
    logic                 cell_strobe_reg;
    cell_t                cell_data_reg;

    logic                 accept;
    logic                 sub_load;
    logic                 sub_shift;
    logic signed [CB:0]   diff_x21;
    logic signed [CB:0]   diff_x12;
    logic signed [CB:0]   diff_y21;
    logic signed [CB:0]   diff_y12;

    logic                 neg_x;
    logic                 neg_y;
    logic [CB-1:0]        adx;
    logic [CB-1:0]        ady;
    logic                 wide_x;
    logic                 swap;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic                 step_x;
    logic [CB-1:0]        ax;
    logic [CB-1:0]        ay;
    logic [CB-1:0]        bx;
    logic [CB-1:0]        by;

    step_ctl_t            ctl;
    logic [CB-1:0]        pos_init;
    logic [CB-1:0]        end_init;
    logic [CB-1:0]        q_init;
    logic [CB-1:0]        span;
    logic signed [CB:0]   delta;
    logic [CB-1:0]        step_pos;
    logic [CB-1:0]        step_quot;
    logic                 step_at_end;
    cell_t                cell_next;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign sub_load  = accept;
    assign sub_shift = (state_reg == ST_SPAN);

    // Span unit: both signed differences on each axis, formed bit-serially.
    lr_serial_sub #(.WIDTH(CB)) u_sub_x21 (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (sub_load),
        .shift (sub_shift),
        .a     (segment.end_x[CB-1:0]),
        .b     (segment.start_x[CB-1:0]),
        .diff  (diff_x21)
    );

    lr_serial_sub #(.WIDTH(CB)) u_sub_x12 (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (sub_load),
        .shift (sub_shift),
        .a     (segment.start_x[CB-1:0]),
        .b     (segment.end_x[CB-1:0]),
        .diff  (diff_x12)
    );

    lr_serial_sub #(.WIDTH(CB)) u_sub_y21 (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (sub_load),
        .shift (sub_shift),
        .a     (segment.end_y[CB-1:0]),
        .b     (segment.start_y[CB-1:0]),
        .diff  (diff_y21)
    );

    lr_serial_sub #(.WIDTH(CB)) u_sub_y12 (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (sub_load),
        .shift (sub_shift),
        .a     (segment.start_y[CB-1:0]),
        .b     (segment.end_y[CB-1:0]),
        .diff  (diff_y12)
    );

    // Order the endpoints. The wider axis decides the ordering; on a tie the
    // rows are ordered, and a diagonal with dx equal to dy (or a single point)
    // still steps along x; the other diagonal steps along y.
    always_comb
    begin
        neg_x  = diff_x21[CB];
        neg_y  = diff_y21[CB];
        adx    = neg_x ? diff_x12[CB-1:0] : diff_x21[CB-1:0];
        ady    = neg_y ? diff_y12[CB-1:0] : diff_y21[CB-1:0];
        wide_x = (adx > ady);
        swap   = wide_x ? neg_x : neg_y;
        dx     = swap ? diff_x12 : diff_x21;
        dy     = swap ? diff_y12 : diff_y21;
        step_x = wide_x || (dx == dy);
        ax     = swap ? x2_reg : x1_reg;
        ay     = swap ? y2_reg : y1_reg;
        bx     = swap ? x1_reg : x2_reg;
        by     = swap ? y1_reg : y2_reg;
        if (step_x)
        begin
            pos_init = ax;
            end_init = bx;
            q_init   = ay;
            span     = dx[CB-1:0];
            delta    = dy;
        end
        else
        begin
            pos_init = ay;
            end_init = by;
            q_init   = ax;
            span     = dy[CB-1:0];
            delta    = dx;
        end
    end

    assign ctl.load    = (state_reg == ST_SETUP);
    assign ctl.advance = (state_reg == ST_RUN);

    lr_step #(.CB(CB)) u_step (
        .clk      (clk),
        .ctl      (ctl),
        .pos_init (pos_init),
        .end_init (end_init),
        .q_init   (q_init),
        .span     (span),
        .delta    (delta),
        .pos      (step_pos),
        .quot     (step_quot),
        .at_end   (step_at_end)
    );

    // Map the stepper's major/minor pair back onto columns and rows.
    always_comb
    begin
        cell_next.cell_x     = COORD_W'(step_x_reg ? step_pos : step_quot);
        cell_next.cell_y     = COORD_W'(step_x_reg ? step_quot : step_pos);
        cell_next.cell_glyph = glyph_reg;
        cell_next.last_cell  = step_at_end;
    end

    // Sequencer with the registered cell output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            cell_strobe_reg <= 1'b0;
        end
        else
        begin
            cell_strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SPAN;
                    end
                end
                ST_SPAN:
                begin
                    // Advance one bit of every span per cycle.
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CB - 1))
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    cell_strobe_reg <= 1'b1;
                    if (step_at_end)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: hold the endpoints and glyph for the whole item, the stepping axis and the cell output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg    <= segment.start_x[CB-1:0];
            y1_reg    <= segment.start_y[CB-1:0];
            x2_reg    <= segment.end_x[CB-1:0];
            y2_reg    <= segment.end_y[CB-1:0];
            glyph_reg <= segment.glyph;
        end
        if (state_reg == ST_SETUP)
        begin
            step_x_reg <= step_x;
        end
        if (state_reg == ST_RUN)
        begin
            cell_data_reg <= cell_next;
        end
    end

    assign cell_strobe = cell_strobe_reg;
    assign cell_data   = cell_data_reg;

`ifndef SYNTH
    // A cell only appears as the product of an item in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_strobe |-> $past(busy))
    else $error("cell strobe without an item in progress");

    // The last cell closes the item: the block is free in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_strobe && cell_data.last_cell) |-> !busy)
    else $error("block still busy after the last cell");

    // Cells of one segment come back to back until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_strobe && !cell_data.last_cell) |=> cell_strobe)
    else $error("gap inside a segment's cells");

    // An accepted item always makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted item did not start");
`endif

endmodule

@@ hw/rtl/lr_serial_sub.sv @@
// Bit-serial subtractor: a - b, one bit per cycle while shift is high, least significant first.
// Depends on lr_pkg (imported for house consistency).
module lr_serial_sub
    import lr_pkg::*;
#(
    parameter int WIDTH = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    shift,
    input  logic [WIDTH-1:0]        a,
    input  logic [WIDTH-1:0]        b,
    output logic signed [WIDTH:0]   diff
);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] d_reg;
    logic             borrow_reg;
    logic             bit_diff;
    logic             bit_borrow;

    // Full subtractor on the current low bits.
    assign bit_diff   = a_reg[0] ^ b_reg[0] ^ borrow_reg;
    assign bit_borrow = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & borrow_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_reg <= 1'b0;
        end
        else if (load)
        begin
            borrow_reg <= 1'b0;
        end
        else if (shift)
        begin
            borrow_reg <= bit_borrow;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (shift)
        begin
            a_reg <= a_reg >> 1;
            b_reg <= b_reg >> 1;
            d_reg <= {bit_diff, d_reg[WIDTH-1:1]};
        end
    end

    // Final borrow is the sign: together they form the two's complement difference.
    assign diff = {borrow_reg, d_reg};

endmodule

@@ hw/rtl/lr_step.sv @@
// Interpolation stepper: while advance is set, walks the major axis one cell per cycle and keeps
// the rounded minor coordinate as a running quotient and remainder. Uses lr_pkg.
module lr_step
    import lr_pkg::*;
#(
    parameter int CB = 6
) (
    input  logic                 clk,
    input  step_ctl_t            ctl,
    input  logic [CB-1:0]        pos_init,
    input  logic [CB-1:0]        end_init,
    input  logic [CB-1:0]        q_init,
    input  logic [CB-1:0]        span,
    input  logic signed [CB:0]   delta,
    output logic [CB-1:0]        pos,
    output logic [CB-1:0]        quot,
    output logic                 at_end
);

    logic [CB-1:0]          pos_reg;
    logic [CB-1:0]          end_reg;
    logic [CB-1:0]          q_reg;
    logic [CB-1:0]          span_reg;
    logic signed [CB:0]     delta_reg;
    logic signed [CB+1:0]   r_reg;
    logic signed [CB+1:0]   r_sum;
    logic signed [CB+1:0]   span_s;
    logic signed [CB+1:0]   r_next;
    logic [CB-1:0]          q_next;

    assign span_s = $signed({2'b00, span_reg});
    assign r_sum  = r_reg + (CB+2)'(delta_reg);

    // |delta| never exceeds the span, so one correction restores the remainder.
    always_comb
    begin
        r_next = r_sum;
        q_next = q_reg;
        if (r_sum < 0)
        begin
            r_next = r_sum + span_s;
            q_next = q_reg - 1'b1;
        end
        else if (r_sum >= span_s)
        begin
            r_next = r_sum - span_s;
            q_next = q_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg   <= pos_init;
            end_reg   <= end_init;
            q_reg     <= q_init;
            span_reg  <= span;
            delta_reg <= delta;
            // Half-span rounding offset.
            r_reg     <= $signed({2'b00, span >> 1});
        end
        else if (ctl.advance)
        begin
            pos_reg <= pos_reg + 1'b1;
            q_reg   <= q_next;
            r_reg   <= r_next;
        end
    end

    assign pos    = pos_reg;
    assign quot   = q_reg;
    assign at_end = (pos_reg == end_reg);

endmodule

@@ tb/line_rasterizer_tb.sv @@
// Self-checking testbench for line_rasterizer: drives segments, predicts every cell.
// Depends on lr_pkg for segment_t, cell_t and COORD_W.
// Covers directed extremes first, then random segments with and without sender gaps.
module line_rasterizer_tb
    import lr_pkg::*;
();

    localparam int COORD_BITS     = 6;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    // Cycles with neither an accepted item nor a cell before giving up.
    localparam int WATCHDOG_LIMIT = 1000;
    // Span unit and stepper load plus a margin; guards against stray cells at the end.
    localparam int SETTLE_CYCLES  = COORD_BITS + 2 + 16;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    segment_t segment;
    logic     cell_strobe;
    cell_t    cell_data;

    // Cells still owed by the block, oldest first.
    cell_t cells_due[$];
    cell_t want_cell;
    int    mismatch_count = 0;
    int    segments_taken = 0;
    int    cells_checked  = 0;
    int    quiet_cycles   = 0;

    line_rasterizer #(.COORD_BITS(COORD_BITS)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .segment     (segment),
        .cell_strobe (cell_strobe),
        .cell_data   (cell_data)
    );

    always #5 clk = ~clk;

    // Rounded interpolation along the stepping axis; span is always positive here.
    function automatic logic [COORD_W-1:0] round_interp(int a, int b, int lo, int hi,
                                                         int pos, int span);
        int num;
        num = a * (hi - pos) + b * (pos - lo) + span / 2;
        return COORD_W'(num / span);
    endfunction

    // Work out every cell of one segment and append them to cells_due in order.
    function automatic void predict_cells(segment_t s);
        int    x1;
        int    y1;
        int    x2;
        int    y2;
        int    adx;
        int    ady;
        int    dx;
        int    dy;
        int    t;
        logic  swap_ends;
        cell_t c;
        x1 = int'(s.start_x);
        y1 = int'(s.start_y);
        x2 = int'(s.end_x);
        y2 = int'(s.end_y);
        adx = (x2 > x1) ? x2 - x1 : x1 - x2;
        ady = (y2 > y1) ? y2 - y1 : y1 - y2;
        // Order by x for shallow lines, by y otherwise.
        swap_ends = (adx > ady) ? (x1 > x2) : (y1 > y2);
        if (swap_ends)
        begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        c.cell_glyph = s.glyph;
        if (dx >= dy && dx == 0)
        begin
            // Coincident endpoints: a single cell.
            c.cell_x    = COORD_W'(x1);
            c.cell_y    = COORD_W'(y1);
            c.last_cell = 1'b1;
            cells_due.push_back(c);
        end
        else if (dx >= dy)
        begin
            // Shallow line or diagonal with dx equal to dy: step x.
            for (t = x1; t <= x2; t++)
            begin
                c.cell_x    = COORD_W'(t);
                c.cell_y    = round_interp(y1, y2, x1, x2, t, dx);
                c.last_cell = (t == x2);
                cells_due.push_back(c);
            end
        end
        else
        begin
            // Steep line or the other diagonal: step y.
            for (t = y1; t <= y2; t++)
            begin
                c.cell_x    = round_interp(x1, x2, y1, y2, t, dy);
                c.cell_y    = COORD_W'(t);
                c.last_cell = (t == y2);
                cells_due.push_back(c);
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // Sample at each rising edge: predict on acceptance, compare each shown cell.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_cells(segment);
                segments_taken++;
            end
            if (cell_strobe)
            begin
                if (cells_due.size() == 0)
                    report_mismatch($sformatf("cell (%0d,%0d) glyph %0d shown with none due",
                                              cell_data.cell_x, cell_data.cell_y,
                                              cell_data.cell_glyph));
                else
                begin
                    want_cell = cells_due.pop_front();
                    cells_checked++;
                    if (cell_data.cell_x !== want_cell.cell_x)
                        report_mismatch($sformatf("cell_x got %0d want %0d",
                                                  cell_data.cell_x, want_cell.cell_x));
                    if (cell_data.cell_y !== want_cell.cell_y)
                        report_mismatch($sformatf("cell_y got %0d want %0d",
                                                  cell_data.cell_y, want_cell.cell_y));
                    if (cell_data.cell_glyph !== want_cell.cell_glyph)
                        report_mismatch($sformatf("cell_glyph got %0d want %0d",
                                                  cell_data.cell_glyph, want_cell.cell_glyph));
                    if (cell_data.last_cell !== want_cell.last_cell)
                        report_mismatch($sformatf("last_cell got %0b want %0b",
                                                  cell_data.last_cell, want_cell.last_cell));
                end
            end
        end
    end

    // Count cycles with no progress on either side; end the run if it stalls.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || cell_strobe)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d cells still due", $time, cells_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic segment_t make_segment(int x1, int y1, int x2, int y2, int g);
        segment_t s;
        s.start_x = COORD_W'(x1);
        s.start_y = COORD_W'(y1);
        s.end_x   = COORD_W'(x2);
        s.end_y   = COORD_W'(y2);
        s.glyph   = GLYPH_W'(g);
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
        return COORD_W'(v);
    endfunction

    // Mostly full-range segments; some short ones near the first endpoint.
    function automatic segment_t random_segment();
        segment_t s;
        s = segment_t'($urandom);
        if ($urandom_range(9) < 3)
        begin
            s.end_x = clamp_coord(int'(s.start_x) + int'($urandom_range(8)) - 4);
            s.end_y = clamp_coord(int'(s.start_y) + int'($urandom_range(8)) - 4);
        end
        return s;
    endfunction

    // Raise start with the item and hold it until the block takes it.
    task automatic send_segment(segment_t s);
        segment <= s;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // With the given chance, drop start for a while and scramble the payload meanwhile.
    task automatic sender_pause(int pct);
        int n;
        if ($urandom_range(99) < pct)
        begin
            n = ($urandom_range(1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 90);
            start <= 1'b0;
            repeat (n)
            begin
                segment <= segment_t'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic test_degenerate();
        send_segment(make_segment(0, 0, 0, 0, 8'h00));
        send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF));
        send_segment(make_segment(17, 42, 17, 42, 8'h5A));
    endtask

    task automatic test_axis_lines();
        send_segment(make_segment(0, 5, COORD_MAX, 5, 8'hAA));
        send_segment(make_segment(COORD_MAX, 5, 0, 5, 8'h55));
        send_segment(make_segment(9, 0, 9, COORD_MAX, 8'h01));
        send_segment(make_segment(9, COORD_MAX, 9, 0, 8'h80));
        send_segment(make_segment(0, 0, 1, 0, 8'h2D));
        send_segment(make_segment(0, 0, 0, 1, 8'h7C));
    endtask

    task automatic test_diagonals();
        send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX, 8'h5C));
        send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0, 8'h2F));
        send_segment(make_segment(0, COORD_MAX, COORD_MAX, 0, 8'h2F));
        send_segment(make_segment(COORD_MAX, 0, 0, COORD_MAX, 8'h5C));
        send_segment(make_segment(10, 10, 11, 11, 8'h2A));
    endtask

    // Half-span ties and spans one apart, in both orderings.
    task automatic test_rounding();
        send_segment(make_segment(0, 0, 2, 1, 8'h23));
        send_segment(make_segment(0, 0, 4, 2, 8'h23));
        send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX - 1, 8'hFE));
        send_segment(make_segment(COORD_MAX - 1, 0, 0, COORD_MAX, 8'h7F));
        send_segment(make_segment(5, 1, 1, 3, 8'h40));
        send_segment(make_segment(1, 5, 3, 1, 8'h3D));
        send_segment(make_segment(0, COORD_MAX, COORD_MAX - 1, 0, 8'hC3));
    endtask

    task automatic test_random(int count, int pause_pct);
        repeat (count)
        begin
            send_segment(random_segment());
            sender_pause(pause_pct);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        segment = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate();
        test_axis_lines();
        test_diagonals();
        test_rounding();
        // Back-to-back items first, then sparse and light sender gaps.
        test_random(100, 0);
        test_random(80, 57);
        test_random(70, 16);

        // Drop start, let the last prediction land, then drain and watch for strays.
        start <= 1'b0;
        @(posedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d segments drawn, %0d cells compared", segments_taken,
                 cells_checked);
        $display("Covered degenerate, axis, diagonal and rounding cases, then random sweeps");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
